FILE: design/emap_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emap_pkg
// Shared constants for the encoder motor angle positioner: command codes,
// configuration register indexes, reset values and fixed field widths.
// ----------------------------------------------------------------------------
package emap_pkg;

    localparam int STEP_WIDTH_DEF = 16;

    localparam int ANGLE_W    = 32;
    localparam int CMD_W      = 2;
    localparam int PPR_W      = 16;
    localparam int DUTY_W     = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [ANGLE_W-1:0] ANGLE_MAX = 32'hFFFF_FFFF;

    // Command codes of an input transaction.
    localparam logic [CMD_W-1:0] CMD_EDGE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_PPR       = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DUTY      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_LOWER     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_UPPER     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_FWD_LEVEL = 3'd4;

    // Register reset values.
    localparam logic [PPR_W-1:0]   PPR_RST   = 16'd1024;
    localparam logic [DUTY_W-1:0]  DUTY_RST  = 8'd128;
    localparam logic [ANGLE_W-1:0] LOWER_RST = 32'd0;
    localparam logic [ANGLE_W-1:0] UPPER_RST = 32'hFFFF_FFFF;

endpackage

FILE: design/encoder_motor_angle_positioner_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_motor_angle_positioner_core
// Bang-bang position control of a motor with a single-channel encoder.
// ----------------------------------------------------------------------------
// Input transactions (i_valid/o_ready) carry a command: an encoder rising edge,
// a move to a target angle, or a stop. Every input transaction produces one
// status transaction on the output channel (o_valid/i_ready) with the drive
// state, direction pin level, PWM duty, step position and the position as an
// angle (full turn is 2^32-1).
// Configuration registers are written through i_cfg_we/i_cfg_addr/i_cfg_data;
// the user must write them only while the block is idle, which the block does
// not enforce; writes take effect on the next transaction. All arithmetic runs
// under one small sequencer: a shift-add multiplier scales a move target to
// steps, and one restoring divider, one quotient bit per cycle, produces the
// position modulo ppr and the angle of the position. A move runs STEP_WIDTH + 1
// multiply steps. The angle divide is skipped when the position is 0 or not
// below ppr. An edge whose stepped position is not below ppr (a forward wrap,
// or a position left high by a ppr change) adds a reduction pass through the
// divider. o_ready is high only while the sequencer is idle; the next
// transaction can be taken in the cycle after the result is loaded. A stalled
// receiver holds the sequencer at its final step until the output register
// frees up.
// Reset (synchronous, active low) restores register defaults, position 0,
// target 0, drive off and forward direction, and empties the output register.
// ----------------------------------------------------------------------------
module encoder_motor_angle_positioner_core #(
    parameter int STEP_WIDTH = emap_pkg::STEP_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port
    input  logic                            i_cfg_we,
    input  logic [emap_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [emap_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Input channel
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [emap_pkg::CMD_W-1:0]      i_cmd,
    input  logic [emap_pkg::ANGLE_W-1:0]    i_target_angle,
    // Output channel
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_drive_on,
    output logic                            o_dir_level,
    output logic [emap_pkg::DUTY_W-1:0]     o_pwm_duty,
    output logic [STEP_WIDTH-1:0]           o_step_position,
    output logic [emap_pkg::ANGLE_W-1:0]    o_angle_now,
    output logic                            o_arrived
);

    localparam int SW = STEP_WIDTH;
    localparam int PW = STEP_WIDTH + 1;              // holds ppr up to 2^SW
    localparam int DW = (PW > 32) ? PW : 32;         // divider shift register
    localparam int CW = $clog2(DW + 1);
    localparam int AW = emap_pkg::ANGLE_W + PW;      // product width

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_MUL,
        S_REDUCE,
        S_AIM,
        S_ANGLE,
        S_DIV,
        S_DONE
    } t_state;

    t_state r_state;

    // Configuration registers
    logic [emap_pkg::PPR_W-1:0]   r_ppr;
    logic [emap_pkg::DUTY_W-1:0]  r_duty;
    logic [emap_pkg::ANGLE_W-1:0] r_lower;
    logic [emap_pkg::ANGLE_W-1:0] r_upper;
    logic                         r_fwd_level;

    // Controller state
    logic [SW-1:0] r_pos;
    logic [SW-1:0] r_tgt;
    logic          r_moving;
    logic          r_fwd;

    // Working registers
    logic [emap_pkg::CMD_W-1:0]   r_cmd;
    logic [emap_pkg::ANGLE_W-1:0] r_angle_in;
    logic [emap_pkg::ANGLE_W-1:0] r_mcand;
    logic [AW-1:0]                r_acc;
    logic [PW-1:0]                r_mbits;
    logic [PW-1:0]                r_tmp;
    logic [CW-1:0]                r_cnt;
    logic [PW-1:0]                r_rem;
    logic [DW-1:0]                r_dvd;
    logic                         r_mod_mode;
    logic                         r_arrived;
    logic [emap_pkg::ANGLE_W-1:0] r_ang;

    // Output register
    logic                         r_out_valid;
    logic                         r_out_drive;
    logic                         r_out_dir;
    logic [emap_pkg::DUTY_W-1:0]  r_out_duty;
    logic [SW-1:0]                r_out_pos;
    logic [emap_pkg::ANGLE_W-1:0] r_out_ang;
    logic                         r_out_arrived;

    // Effective ppr, clamped to [2, 2^SW].
    logic [32:0]   w_ppr_ext;
    logic [32:0]   w_ppr_lim;
    logic [32:0]   w_ppr_clamp;
    logic [PW-1:0] w_ppr;
    logic [PW-1:0] w_ppr_m1;

    always_comb begin
        w_ppr_ext = 33'(r_ppr);
        w_ppr_lim = 33'd1 << SW;
        if (w_ppr_ext < 33'd2) begin
            w_ppr_clamp = 33'd2;
        end else if (w_ppr_ext > w_ppr_lim) begin
            w_ppr_clamp = w_ppr_lim;
        end else begin
            w_ppr_clamp = w_ppr_ext;
        end
        w_ppr    = w_ppr_clamp[PW-1:0];
        w_ppr_m1 = w_ppr - PW'(1);
    end

    // Angle clamp and bound mode.
    logic [emap_pkg::ANGLE_W-1:0] w_clamped;
    logic                         w_full_turn;

    always_comb begin
        if (r_angle_in < r_lower) begin
            w_clamped = r_lower;
        end else if (r_angle_in > r_upper) begin
            w_clamped = r_upper;
        end else begin
            w_clamped = r_angle_in;
        end
        w_full_turn = (r_lower == '0) && (r_upper == emap_pkg::ANGLE_MAX);
    end

    // Edge step before the modulo reduction.
    logic [PW-1:0] w_edge_v;
    logic          w_edge_fit;

    always_comb begin
        if (r_fwd) begin
            w_edge_v = PW'(r_pos) + PW'(1);
        end else if (r_pos == '0) begin
            w_edge_v = w_ppr_m1;
        end else begin
            w_edge_v = PW'(r_pos) - PW'(1);
        end
        w_edge_fit = w_edge_v < w_ppr;
    end

    // Product divided by 2^32-1: hi + floor((hi + lo) / (2^32-1)).
    logic [PW-1:0] w_hi;
    logic [33:0]   w_sum;
    logic [1:0]    w_q;
    logic [PW-1:0] w_scaled;

    always_comb begin
        w_hi  = r_acc[AW-1:32];
        w_sum = 34'(w_hi) + 34'(r_acc[31:0]);
        if (w_sum >= {1'b0, emap_pkg::ANGLE_MAX, 1'b0}) begin
            w_q = 2'd2;
        end else if (w_sum >= 34'(emap_pkg::ANGLE_MAX)) begin
            w_q = 2'd1;
        end else begin
            w_q = 2'd0;
        end
        w_scaled = w_hi + PW'(w_q);
    end

    // Target and direction choice for a move.
    logic [PW-1:0]        w_t0;
    logic signed [SW+2:0] w_diff;
    logic signed [SW+2:0] w_d1;
    logic signed [SW+2:0] w_d2;
    logic signed [SW+2:0] w_half_s;
    logic signed [SW+2:0] w_ppr_s;
    logic                 w_aim_fwd;
    logic                 w_aim_hit;

    always_comb begin
        if (w_full_turn) begin
            w_t0 = (r_tmp >= w_ppr) ? '0 : r_tmp;
        end else begin
            w_t0 = (r_tmp > w_ppr_m1) ? w_ppr_m1 : r_tmp;
        end
        w_ppr_s  = $signed({2'b00, w_ppr});
        w_half_s = $signed({3'b000, w_ppr[PW-1:1]});
        w_diff   = $signed({2'b00, w_t0}) - $signed({3'b000, r_pos});
        w_d1     = (w_diff > w_half_s) ? (w_diff - w_ppr_s) : w_diff;
        w_d2     = (w_d1 < -w_half_s) ? (w_d1 + w_ppr_s) : w_d1;
        if (w_full_turn) begin
            w_aim_fwd = w_d2 > 0;
        end else begin
            w_aim_fwd = w_t0 > PW'(r_pos);
        end
        w_aim_hit = PW'(r_pos) == w_t0;
    end

    // Shared restoring divider step by ppr.
    logic [PW:0]   w_rem_sh;
    logic          w_ge;
    logic [PW:0]   w_rem_sub;
    logic [PW-1:0] n_rem;
    logic [DW-1:0] n_dvd;

    always_comb begin
        w_rem_sh  = {r_rem, r_dvd[DW-1]};
        w_ge      = w_rem_sh >= {1'b0, w_ppr};
        w_rem_sub = w_rem_sh - {1'b0, w_ppr};
        n_rem     = w_ge ? w_rem_sub[PW-1:0] : w_rem_sh[PW-1:0];
        n_dvd     = {r_dvd[DW-2:0], w_ge};
    end

    // Angle operands: pos * (2^32-1) = (pos-1) * 2^32 + (2^32 - pos).
    logic [emap_pkg::ANGLE_W-1:0] w_ang_lo;

    assign w_ang_lo = ~emap_pkg::ANGLE_W'(r_pos) + emap_pkg::ANGLE_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ppr       <= emap_pkg::PPR_RST;
            r_duty      <= emap_pkg::DUTY_RST;
            r_lower     <= emap_pkg::LOWER_RST;
            r_upper     <= emap_pkg::UPPER_RST;
            r_fwd_level <= 1'b1;
            r_pos       <= '0;
            r_tgt       <= '0;
            r_moving    <= 1'b0;
            r_fwd       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    emap_pkg::REG_PPR:       r_ppr       <= i_cfg_data[emap_pkg::PPR_W-1:0];
                    emap_pkg::REG_DUTY:      r_duty      <= i_cfg_data[emap_pkg::DUTY_W-1:0];
                    emap_pkg::REG_LOWER:     r_lower     <= i_cfg_data;
                    emap_pkg::REG_UPPER:     r_upper     <= i_cfg_data;
                    emap_pkg::REG_FWD_LEVEL: r_fwd_level <= i_cfg_data[0];
                    default: ;
                endcase
            end

            // In S_DONE the output register is reloaded instead.
            if (r_out_valid && i_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd      <= i_cmd;
                        r_angle_in <= i_target_angle;
                        r_arrived  <= 1'b0;
                        r_state    <= S_DISPATCH;
                    end
                end

                S_DISPATCH: begin
                    case (r_cmd)
                        emap_pkg::CMD_EDGE: begin
                            if (w_edge_fit) begin
                                r_pos <= w_edge_v[SW-1:0];
                                if (r_moving && (w_edge_v[SW-1:0] == r_tgt)) begin
                                    r_moving  <= 1'b0;
                                    r_arrived <= 1'b1;
                                end
                                r_state <= S_ANGLE;
                            end else begin
                                // Stepped position not below ppr: reduce it by division.
                                r_rem      <= '0;
                                r_dvd      <= DW'(w_edge_v);
                                r_cnt      <= CW'(DW);
                                r_mod_mode <= 1'b1;
                                r_state    <= S_DIV;
                            end
                        end
                        emap_pkg::CMD_MOVE: begin
                            r_mcand <= w_clamped;
                            r_acc   <= '0;
                            r_mbits <= w_ppr;
                            r_cnt   <= CW'(PW);
                            r_state <= S_MUL;
                        end
                        emap_pkg::CMD_STOP: begin
                            r_moving <= 1'b0;
                            r_state  <= S_ANGLE;
                        end
                        default: begin
                            r_state <= S_ANGLE;
                        end
                    endcase
                end

                S_MUL: begin
                    // MSB-first shift-add of the clamped angle times ppr.
                    r_acc   <= (r_acc << 1) + (r_mbits[PW-1] ? AW'(r_mcand) : '0);
                    r_mbits <= r_mbits << 1;
                    r_cnt   <= r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        r_state <= S_REDUCE;
                    end
                end

                S_REDUCE: begin
                    r_tmp   <= w_scaled;
                    r_state <= S_AIM;
                end

                S_AIM: begin
                    r_tgt <= w_t0[SW-1:0];
                    if (w_aim_hit) begin
                        r_moving  <= 1'b0;
                        r_arrived <= 1'b1;
                    end else begin
                        r_moving <= 1'b1;
                        r_fwd    <= w_aim_fwd;
                    end
                    r_state <= S_ANGLE;
                end

                S_ANGLE: begin
                    if (PW'(r_pos) >= w_ppr) begin
                        r_ang   <= emap_pkg::ANGLE_MAX;
                        r_state <= S_DONE;
                    end else if (r_pos == '0) begin
                        r_ang   <= '0;
                        r_state <= S_DONE;
                    end else begin
                        // High word is below ppr, so the quotient fits 32 bits.
                        r_rem      <= PW'(r_pos) - PW'(1);
                        r_dvd      <= DW'(w_ang_lo) << (DW - emap_pkg::ANGLE_W);
                        r_cnt      <= CW'(emap_pkg::ANGLE_W);
                        r_mod_mode <= 1'b0;
                        r_state    <= S_DIV;
                    end
                end

                S_DIV: begin
                    r_rem <= n_rem;
                    r_dvd <= n_dvd;
                    r_cnt <= r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        if (r_mod_mode) begin
                            r_pos <= n_rem[SW-1:0];
                            if (r_moving && (n_rem[SW-1:0] == r_tgt)) begin
                                r_moving  <= 1'b0;
                                r_arrived <= 1'b1;
                            end
                            r_state <= S_ANGLE;
                        end else begin
                            r_ang   <= n_dvd[emap_pkg::ANGLE_W-1:0];
                            r_state <= S_DONE;
                        end
                    end
                end

                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid   <= 1'b1;
                        r_out_drive   <= r_moving;
                        r_out_dir     <= r_fwd ? r_fwd_level : ~r_fwd_level;
                        r_out_duty    <= r_moving ? r_duty : '0;
                        r_out_pos     <= r_pos;
                        r_out_ang     <= r_ang;
                        r_out_arrived <= r_arrived;
                        r_state       <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_drive_on      = r_out_drive;
    assign o_dir_level     = r_out_dir;
    assign o_pwm_duty      = r_out_duty;
    assign o_step_position = r_out_pos;
    assign o_angle_now     = r_out_ang;
    assign o_arrived       = r_out_arrived;

endmodule

FILE: tb/tb_encoder_motor_angle_positioner_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_encoder_motor_angle_positioner_core
// Self-checking bench for the motor angle positioner. A tracker keeps its own
// copy of position, target, drive state and registers, predicts the status
// of every accepted command and checks each status transaction in order.
// Directed commands cover wrap-around, the shorter way, arrival and stale
// positions after a ppr change. Random phases then run move-and-edge
// sequences under many register settings, with random gaps on both sides.
// ----------------------------------------------------------------------------
typedef struct {
    logic                          drive_on;
    logic                          dir_level;
    logic [emap_pkg::DUTY_W-1:0]   pwm_duty;
    logic [15:0]                   step_position;
    logic [emap_pkg::ANGLE_W-1:0]  angle_now;
    logic                          arrived;
} t_motor_status;

class positioner_tracker;
    logic [emap_pkg::PPR_W-1:0]   ppr_reg   = emap_pkg::PPR_RST;
    logic [emap_pkg::DUTY_W-1:0]  duty_reg  = emap_pkg::DUTY_RST;
    logic [emap_pkg::ANGLE_W-1:0] lower_reg = emap_pkg::LOWER_RST;
    logic [emap_pkg::ANGLE_W-1:0] upper_reg = emap_pkg::UPPER_RST;
    bit                           fwd_level = 1'b1;

    longint unsigned    position  = 0;
    longint unsigned    target    = 0;
    bit                 moving    = 1'b0;
    bit                 forward   = 1'b1;

    t_motor_status      pending_status[$];
    int                 errors    = 0;

    function void write_reg(logic [emap_pkg::CFG_ADDR_W-1:0] addr,
                            logic [emap_pkg::CFG_DATA_W-1:0] data);
        case (addr)
            emap_pkg::REG_PPR:       ppr_reg   = data[emap_pkg::PPR_W-1:0];
            emap_pkg::REG_DUTY:      duty_reg  = data[emap_pkg::DUTY_W-1:0];
            emap_pkg::REG_LOWER:     lower_reg = data;
            emap_pkg::REG_UPPER:     upper_reg = data;
            emap_pkg::REG_FWD_LEVEL: fwd_level = data[0];
            default: ;
        endcase
    endfunction

    function bit idle();
        return pending_status.size() == 0;
    endfunction

    // Works out the status that one accepted command produces.
    function void note_command(logic [emap_pkg::CMD_W-1:0] cmd,
                               logic [emap_pkg::ANGLE_W-1:0] angle);
        t_motor_status   s;
        longint unsigned ppr;
        longint unsigned clamped;
        longint unsigned steps;
        longint unsigned ang;
        longint          diff;
        longint          half;
        bit              go_fwd;
        s.arrived = 1'b0;
        ppr = (ppr_reg < 2) ? 2 : ppr_reg;
        case (cmd)
            emap_pkg::CMD_EDGE: begin
                if (forward)
                    position = (position + 1) % ppr;
                else if (position == 0)
                    position = ppr - 1;
                else
                    position = (position - 1) % ppr;
                if (moving && position == target) begin
                    moving = 1'b0;
                    s.arrived = 1'b1;
                end
            end
            emap_pkg::CMD_MOVE: begin
                clamped = angle;
                if (angle < lower_reg)
                    clamped = lower_reg;
                else if (angle > upper_reg)
                    clamped = upper_reg;
                steps = (clamped * ppr) / 64'hFFFF_FFFF;
                if (lower_reg == 0 && upper_reg == emap_pkg::ANGLE_MAX) begin
                    // Full turn allowed: wrap and take the shorter way round.
                    half = longint'(ppr / 2);
                    if (steps >= ppr)
                        steps = 0;
                    diff = longint'(steps) - longint'(position);
                    if (diff > half)
                        diff = diff - longint'(ppr);
                    if (diff < -half)
                        diff = diff + longint'(ppr);
                    go_fwd = diff > 0;
                end else begin
                    if (steps > ppr - 1)
                        steps = ppr - 1;
                    go_fwd = steps > position;
                end
                target = steps;
                if (position == steps) begin
                    moving = 1'b0;
                    s.arrived = 1'b1;
                end else begin
                    moving = 1'b1;
                    forward = go_fwd;
                end
            end
            emap_pkg::CMD_STOP: moving = 1'b0;
            default: ;
        endcase
        ang = (position * 64'hFFFF_FFFF) / ppr;
        if (ang > 64'hFFFF_FFFF)
            ang = 64'hFFFF_FFFF;
        s.drive_on      = moving;
        s.dir_level     = forward ? fwd_level : ~fwd_level;
        s.pwm_duty      = moving ? duty_reg : '0;
        s.step_position = position[15:0];
        s.angle_now     = ang[emap_pkg::ANGLE_W-1:0];
        pending_status.push_back(s);
    endfunction

    function void compare(string name, logic [63:0] exp_val, logic [63:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
            errors++;
        end
    endfunction

    function void check_status(t_motor_status got);
        t_motor_status exp_s;
        if (pending_status.size() == 0) begin
            $error("status transaction with no command outstanding");
            errors++;
            return;
        end
        exp_s = pending_status.pop_front();
        compare("drive_on", exp_s.drive_on, got.drive_on);
        compare("dir_level", exp_s.dir_level, got.dir_level);
        compare("pwm_duty", exp_s.pwm_duty, got.pwm_duty);
        compare("step_position", exp_s.step_position, got.step_position);
        compare("angle_now", exp_s.angle_now, got.angle_now);
        compare("arrived", exp_s.arrived, got.arrived);
    endfunction
endclass

module tb_encoder_motor_angle_positioner_core;

    localparam int                         CYCLE_LIMIT = 1_000_000;
    localparam logic [emap_pkg::CMD_W-1:0] CMD_NONE    = 2'd3;

    logic                            i_clk;
    logic                            i_rst_n        = 1'b0;
    logic                            i_cfg_we       = 1'b0;
    logic [emap_pkg::CFG_ADDR_W-1:0] i_cfg_addr     = '0;
    logic [emap_pkg::CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                            i_valid        = 1'b0;
    logic                            o_ready;
    logic [emap_pkg::CMD_W-1:0]      i_cmd          = emap_pkg::CMD_EDGE;
    logic [emap_pkg::ANGLE_W-1:0]    i_target_angle = '0;
    logic                            o_valid;
    logic                            i_ready        = 1'b0;
    logic                            o_drive_on;
    logic                            o_dir_level;
    logic [emap_pkg::DUTY_W-1:0]     o_pwm_duty;
    logic [15:0]                     o_step_position;
    logic [emap_pkg::ANGLE_W-1:0]    o_angle_now;
    logic                            o_arrived;

    positioner_tracker sb = new();
    bit                quiet = 1'b1;

    encoder_motor_angle_positioner_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd          (i_cmd),
        .i_target_angle (i_target_angle),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_drive_on     (o_drive_on),
        .o_dir_level    (o_dir_level),
        .o_pwm_duty     (o_pwm_duty),
        .o_step_position(o_step_position),
        .o_angle_now    (o_angle_now),
        .o_arrived      (o_arrived)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly back to back, some short gaps and the odd long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [emap_pkg::ANGLE_W-1:0] rand_angle(
            logic [emap_pkg::ANGLE_W-1:0] lo, logic [emap_pkg::ANGLE_W-1:0] hi);
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return emap_pkg::ANGLE_MAX;
            2:       return lo;
            3:       return hi;
            4:       return lo - 1;
            5:       return hi + 1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input logic [emap_pkg::CMD_W-1:0] cmd,
                             input logic [emap_pkg::ANGLE_W-1:0] angle);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_cmd          <= cmd;
        i_target_angle <= angle;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        sb.note_command(cmd, angle);
    endtask

    // Holds the sender until every status has come back, plus a short pad.
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (!sb.idle());
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [emap_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [emap_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        sb.write_reg(addr, data);
        @(posedge i_clk);
    endtask

    task automatic apply_config(input logic [emap_pkg::PPR_W-1:0] ppr,
                                input logic [emap_pkg::DUTY_W-1:0] duty,
                                input logic [emap_pkg::ANGLE_W-1:0] lo,
                                input logic [emap_pkg::ANGLE_W-1:0] hi,
                                input bit fwd);
        cfg_write(emap_pkg::REG_PPR, 32'(ppr));
        cfg_write(emap_pkg::REG_DUTY, 32'(duty));
        cfg_write(emap_pkg::REG_LOWER, lo);
        cfg_write(emap_pkg::REG_UPPER, hi);
        cfg_write(emap_pkg::REG_FWD_LEVEL, 32'(fwd));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_phase(input int n, input logic [emap_pkg::PPR_W-1:0] ppr,
                             input logic [emap_pkg::DUTY_W-1:0] duty,
                             input logic [emap_pkg::ANGLE_W-1:0] lo,
                             input logic [emap_pkg::ANGLE_W-1:0] hi, input bit fwd);
        int sent;
        int span;
        int r;
        bit held;
        wait_drained();
        apply_config(ppr, duty, lo, hi, fwd);
        quiet = ($urandom_range(0, 3) == 0);
        span  = (ppr < 2) ? 2 : ((ppr > 46) ? 48 : ppr + 2);
        sent  = 0;
        held  = 1'b0;
        while (sent < n) begin
            if (!held && sent >= n / 2) begin
                held = 1'b1;
                wait_drained();
            end
            r = $urandom_range(0, 99);
            if (r < 60) begin
                // A move followed by enough edges to reach the target most times.
                send_item(emap_pkg::CMD_MOVE, rand_angle(lo, hi));
                sent++;
                repeat ($urandom_range(1, span)) begin
                    if ($urandom_range(0, 19) == 0)
                        send_item(emap_pkg::CMD_STOP, $urandom);
                    else
                        send_item(emap_pkg::CMD_EDGE, $urandom);
                    sent++;
                end
            end else if (r < 75) begin
                send_item(emap_pkg::CMD_EDGE, $urandom);
                sent++;
            end else if (r < 85) begin
                send_item(emap_pkg::CMD_STOP, $urandom);
                sent++;
            end else if (r < 92) begin
                send_item(CMD_NONE, $urandom);
                sent++;
            end else begin
                send_item(emap_pkg::CMD_MOVE, rand_angle(lo, hi));
                sent++;
            end
        end
    endtask

    // Status receiver with random back-pressure.
    initial begin
        t_motor_status got;
        int            stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid === 1'b1 && i_ready) begin
                got.drive_on      = o_drive_on;
                got.dir_level     = o_dir_level;
                got.pwm_duty      = o_pwm_duty;
                got.step_position = o_step_position;
                got.angle_now     = o_angle_now;
                got.arrived       = o_arrived;
                sb.check_status(got);
            end
            if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0)
                stall_left = pick_gap();
            if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("** encoder_motor_angle_positioner_core: FAILED **");
        $finish;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        quiet = 1'b0;

        // Reset settings: 1024 steps per turn, full-turn bounds.
        send_item(emap_pkg::CMD_EDGE, '0);                  // idle edge still steps forward
        send_item(emap_pkg::CMD_MOVE, '0);                  // shorter way back is reverse
        send_item(emap_pkg::CMD_EDGE, emap_pkg::ANGLE_MAX); // arrives at zero
        send_item(emap_pkg::CMD_MOVE, '0);                  // already there
        send_item(emap_pkg::CMD_MOVE, emap_pkg::ANGLE_MAX); // full turn wraps to zero
        send_item(emap_pkg::CMD_MOVE, 32'h8000_0000);       // exactly half a turn goes forward
        send_item(emap_pkg::CMD_STOP, 32'h5555_AAAA);
        send_item(CMD_NONE, emap_pkg::ANGLE_MAX);
        send_item(emap_pkg::CMD_EDGE, '0);
        send_item(emap_pkg::CMD_MOVE, 32'hFF00_0000);       // near the top: reverse through zero
        repeat (6) send_item(emap_pkg::CMD_EDGE, '0);

        // Position left far above a tiny ppr; angle saturates, edges reduce it.
        wait_drained();
        apply_config(16'd2, 8'd255, emap_pkg::LOWER_RST, emap_pkg::UPPER_RST, 1'b0);
        send_item(CMD_NONE, '0);
        send_item(emap_pkg::CMD_EDGE, '0);
        send_item(emap_pkg::CMD_EDGE, '0);

        // Reverse move on the largest ppr, then shrink ppr under the target.
        wait_drained();
        apply_config(16'hFFFF, 8'd77, emap_pkg::LOWER_RST, emap_pkg::UPPER_RST, 1'b1);
        send_item(emap_pkg::CMD_MOVE, 32'hF000_0000);
        send_item(emap_pkg::CMD_EDGE, '0);
        send_item(emap_pkg::CMD_EDGE, '0);
        wait_drained();
        apply_config(16'd5, 8'd77, emap_pkg::LOWER_RST, emap_pkg::UPPER_RST, 1'b1);
        repeat (3) send_item(emap_pkg::CMD_EDGE, '0);
        send_item(emap_pkg::CMD_STOP, '0);

        run_phase(110, emap_pkg::PPR_RST, emap_pkg::DUTY_RST, emap_pkg::LOWER_RST,
                  emap_pkg::UPPER_RST, 1'b1);
        run_phase(100, 16'd0, 8'd0, emap_pkg::LOWER_RST, emap_pkg::UPPER_RST, 1'b0);
        run_phase(100, 16'd1, 8'd255, 32'h4000_0000, 32'hC000_0000, 1'b1);
        run_phase(110, 16'd12, 8'($urandom), 32'd0, 32'hFFFF_FFFE, 1'b0);
        run_phase(110, 16'd37, 8'($urandom), 32'hC000_0000, 32'h4000_0000, 1'b1);
        run_phase(60, 16'hFFFF, 8'd255, emap_pkg::LOWER_RST, emap_pkg::UPPER_RST, 1'b0);
        run_phase(100, 16'd3, 8'd1, emap_pkg::ANGLE_MAX, emap_pkg::ANGLE_MAX, 1'b0);
        run_phase(110, 16'($urandom_range(2, 64)), 8'($urandom), 32'd1,
                  emap_pkg::ANGLE_MAX, 1'b1);
        run_phase(110, 16'd8, 8'd254, emap_pkg::LOWER_RST, emap_pkg::UPPER_RST, 1'b1);

        wait_drained();
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0)
            $display("** encoder_motor_angle_positioner_core: PASSED **");
        else
            $display("** encoder_motor_angle_positioner_core: FAILED **");
        $finish;
    end

endmodule
